// File: hdl/keypad_scan_debounce_edge_core_macros.svh
// Assertion macros for the keypad scan core.
// No dependencies; included by the files that carry assertions.
`ifndef KEYPAD_SCAN_DEBOUNCE_EDGE_CORE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_EDGE_CORE_MACROS_SVH

// Checked every cycle outside reset.
`define KSDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked every cycle, reset included.
`define KSDE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/ksde_pkg.sv
// Shared types, sizes and key map for the keypad scan core.
// No dependencies.
package ksde_pkg;

  localparam int HISTORY_DEPTH = 5;
  localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int COLS = 4;
  localparam int ROWS = 4;
  localparam int KEYS = COLS * ROWS;

  typedef struct packed {
    logic [3:0] col0_rows;
    logic [3:0] col1_rows;
    logic [3:0] col2_rows;
    logic [3:0] col3_rows;
  } ksde_scan_t;

  typedef struct packed {
    logic        key_valid;
    logic [6:0]  key_char;
    logic [3:0]  key_index;
    logic [15:0] pressed_map;
  } ksde_result_t;

  // history write control, shared by all column lanes
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } ksde_wr_t;

  // ASCII for key at index row*4 + column
  function automatic logic [6:0] key_ascii(input logic [3:0] idx);
    logic [6:0] ch;
    case (idx)
      4'd0:    ch = 7'h31; // 1
      4'd1:    ch = 7'h32; // 2
      4'd2:    ch = 7'h33; // 3
      4'd3:    ch = 7'h41; // A
      4'd4:    ch = 7'h34; // 4
      4'd5:    ch = 7'h35; // 5
      4'd6:    ch = 7'h36; // 6
      4'd7:    ch = 7'h42; // B
      4'd8:    ch = 7'h37; // 7
      4'd9:    ch = 7'h38; // 8
      4'd10:   ch = 7'h39; // 9
      4'd11:   ch = 7'h43; // C
      4'd12:   ch = 7'h2A; // *
      4'd13:   ch = 7'h30; // 0
      4'd14:   ch = 7'h23; // #
      4'd15:   ch = 7'h44; // D
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/ksde_lane.sv
// One column lane: ring of inverted row samples and the all-pressed reduce.
// Depends on ksde_pkg.
module ksde_lane import ksde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ksde_wr_t   wr,
  input  logic [3:0] rows_n,
  output logic [3:0] held
);

  logic [3:0] history [HISTORY_DEPTH];
  logic [3:0] sample;

  assign sample = ~rows_n;

  // slot being overwritten contributes the new sample instead of its old value
  always_comb begin
    held = sample;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (SLOT_W'(k) != wr.slot) begin
        held = held & history[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        history[k] <= '0;
      end
    end else if (wr.en) begin
      history[wr.slot] <= sample;
    end
  end

endmodule

// File: hdl/ksde_merge.sv
// Merge stage: press edges against the previous map, column-major first hit.
// Depends on ksde_pkg.
module ksde_merge import ksde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [15:0]  now,
  output ksde_result_t res
);

  logic [15:0] previous_pressed;
  logic [15:0] rising;
  logic        found;
  logic [3:0]  hit;
  logic [3:0]  idx;

  assign rising = now & ~previous_pressed;

  // bit c*4+r; lowest set bit wins
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = KEYS - 1; i >= 0; i--) begin
      if (rising[i]) begin
        found = 1'b1;
        hit   = 4'(i);
      end
    end
  end

  assign idx = found ? {hit[1:0], hit[3:2]} : 4'd0;

  always_comb begin
    res.key_valid   = found;
    res.key_index   = idx;
    res.key_char    = found ? key_ascii(idx) : 7'd0;
    res.pressed_map = now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pressed <= '0;
    end else if (en) begin
      previous_pressed <= now;
    end
  end

endmodule

// File: hdl/keypad_scan_debounce_edge_core.sv
// Top level of the keypad scan core: column lanes, merge stage, output register.
// Depends on ksde_pkg, ksde_lane, ksde_merge and the assertion macro header.
//
// Usage:
//   scan channel (scan_valid/scan_ready/scan): one transaction is one full
//   keypad scan, the active-low row levels seen for each driven column.
//   result channel (result_valid/result_ready/result): exactly one
//   transaction per scan, with the debounced map and the first new press.
//   Latency: the result is valid the cycle after the scan is taken.
//   Throughput: one scan per cycle; four column lanes update their sample
//   rings and reduce them in parallel, and the merge stage finds the first
//   press edge in the same cycle, feeding a single output register.
//   scan_ready is high while the output register is empty or being read, so
//   a stalled receiver holds one result and stops further scans until it
//   takes it; nothing is dropped.
//   Reset (rst, synchronous) clears all sample history, the ring position
//   and the previous map at once; no key reads as pressed until
//   HISTORY_DEPTH consecutive scans show it.
`include "keypad_scan_debounce_edge_core_macros.svh"

module keypad_scan_debounce_edge_core import ksde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         scan_valid,
  output logic         scan_ready,
  input  ksde_scan_t   scan,
  output logic         result_valid,
  input  logic         result_ready,
  output ksde_result_t result
);

  logic              accept;
  logic [SLOT_W-1:0] history_slot;
  logic [SLOT_W-1:0] history_slot_next;
  ksde_wr_t          wr;
  logic [3:0]        rows_n [COLS];
  logic [15:0]       now;
  ksde_result_t      res;

  assign scan_ready = !result_valid || result_ready;
  assign accept     = scan_valid && scan_ready;

  assign history_slot_next = (history_slot == SLOT_W'(HISTORY_DEPTH - 1)) ?
                             '0 : history_slot + 1'b1;

  assign wr.en   = accept;
  assign wr.slot = history_slot;

  assign rows_n[0] = scan.col0_rows;
  assign rows_n[1] = scan.col1_rows;
  assign rows_n[2] = scan.col2_rows;
  assign rows_n[3] = scan.col3_rows;

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    ksde_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .rows_n (rows_n[c]),
      .held   (now[c*ROWS +: ROWS])
    );
  end

  ksde_merge u_merge (
    .clk (clk),
    .rst (rst),
    .en  (accept),
    .now (now),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      history_slot <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        history_slot <= history_slot_next;
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

  `KSDE_ASSERT(a_scan_gives_result, accept |=> result_valid, "accepted scan left no result")
  `KSDE_ASSERT(a_reported_key_held,
    result_valid && result.key_valid |->
      result.pressed_map[{result.key_index[1:0], result.key_index[3:2]}],
    "reported key is not in the debounced map")
  `KSDE_ASSERT(a_slot_in_range, history_slot <= SLOT_W'(HISTORY_DEPTH - 1),
    "history slot beyond ring depth")
  `KSDE_ASSERT(a_slot_advances, accept |=> history_slot != $past(history_slot) ||
    HISTORY_DEPTH == 1, "history slot did not advance on a scan")
  `KSDE_ASSERT_ALWAYS(a_reset_clears_valid, rst |=> !result_valid,
    "result valid after reset")

endmodule

// File: dv/keypad_scan_checker.sv
`timescale 1ns / 1ps
// Checker for the keypad scan core: watches both channels, tracks the debounce
// history itself and compares every result transaction. Depends on ksde_pkg.
module keypad_scan_checker import ksde_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         scan_valid,
  input  logic         scan_ready,
  input  ksde_scan_t   scan,
  input  logic         result_valid,
  input  logic         result_ready,
  input  ksde_result_t result,
  output int           fail_count,
  output int           pending
);

  // key legend indexed by row*4 + column
  localparam byte KEY_CHARS [KEYS] = '{"1", "2", "3", "A",
                                       "4", "5", "6", "B",
                                       "7", "8", "9", "C",
                                       "*", "0", "#", "D"};

  logic [3:0]   pressed_hist [COLS][HISTORY_DEPTH];
  int unsigned  ring_pos;
  logic [15:0]  last_map;
  ksde_result_t key_reports_q [$];
  ksde_result_t want;

  initial fail_count = 0;
  assign pending = key_reports_q.size();

  task automatic report(input string msg);
    fail_count++;
    $display("%0t checker: %s", $realtime, msg);
  endtask

  function automatic void clear_history();
    for (int c = 0; c < COLS; c++)
      for (int k = 0; k < HISTORY_DEPTH; k++)
        pressed_hist[c][k] = '0;
    ring_pos = 0;
    last_map = '0;
  endfunction

  // one scan: store inverted rows, AND over the ring, find first new press
  function automatic ksde_result_t debounce_scan(input ksde_scan_t s);
    logic [3:0]   raw [COLS];
    logic [3:0]   all_on;
    logic [15:0]  now_map;
    logic [15:0]  fresh;
    ksde_result_t rep;
    raw[0] = s.col0_rows;
    raw[1] = s.col1_rows;
    raw[2] = s.col2_rows;
    raw[3] = s.col3_rows;
    now_map = '0;
    for (int c = 0; c < COLS; c++) begin
      pressed_hist[c][ring_pos] = ~raw[c];
      all_on = 4'hF;
      for (int k = 0; k < HISTORY_DEPTH; k++) all_on &= pressed_hist[c][k];
      now_map[c*4 +: 4] = all_on;
    end
    ring_pos = (ring_pos == HISTORY_DEPTH - 1) ? 0 : ring_pos + 1;
    fresh = now_map & ~last_map;
    last_map = now_map;
    rep = '0;
    rep.pressed_map = now_map;
    // column outer, row inner; later edges in the same scan are lost
    for (int c = 0; c < COLS; c++)
      for (int r = 0; r < ROWS; r++)
        if (!rep.key_valid && fresh[c*4 + r]) begin
          rep.key_valid = 1'b1;
          rep.key_index = 4'(r*4 + c);
          rep.key_char  = KEY_CHARS[r*4 + c][6:0];
        end
    return rep;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      key_reports_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (key_reports_q.size() == 0) begin
          report($sformatf("unexpected result transaction %h", result));
        end else begin
          want = key_reports_q.pop_front();
          if (result.key_valid !== want.key_valid)
            report($sformatf("key_valid got %b want %b", result.key_valid, want.key_valid));
          if (result.key_char !== want.key_char)
            report($sformatf("key_char got %h want %h", result.key_char, want.key_char));
          if (result.key_index !== want.key_index)
            report($sformatf("key_index got %0d want %0d",
                             result.key_index, want.key_index));
          if (result.pressed_map !== want.pressed_map)
            report($sformatf("pressed_map got %h want %h",
                             result.pressed_map, want.pressed_map));
        end
      end
      if (scan_valid && scan_ready) key_reports_q.push_back(debounce_scan(scan));
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the keypad scan core testbench: clock, reset, scan stimulus, result
// back-pressure and verdict. Depends on ksde_pkg and keypad_scan_checker.
module testbench;
  import ksde_pkg::*;

  localparam int SCAN_TARGET = 1350;
  localparam int QUIET_FROM  = 1150;
  localparam int STALL_LIMIT = 1000;

  logic         clk;
  logic         rst;
  logic         scan_valid;
  logic         scan_ready;
  ksde_scan_t   scan;
  logic         result_valid;
  logic         result_ready;
  ksde_result_t result;
  int           fail_count;
  int           pending;

  int           scans_sent = 0;
  bit           quiet = 1'b0;
  int           gap_pct = 20;
  int           stall_cycles = 0;
  logic [15:0]  held_now = '0;

  keypad_scan_debounce_edge_core dut (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_ready   (scan_ready),
    .scan         (scan),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  keypad_scan_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_ready   (scan_ready),
    .scan         (scan),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // held keys (bit column*4 + row) to active-low raw rows
  function automatic ksde_scan_t scan_of(input logic [15:0] held);
    ksde_scan_t s;
    s.col0_rows = ~held[3:0];
    s.col1_rows = ~held[7:4];
    s.col2_rows = ~held[11:8];
    s.col3_rows = ~held[15:12];
    return s;
  endfunction

  task automatic push_scan(input ksde_scan_t s);
    if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
      scan_valid <= 1'b0;
      scan       <= ksde_scan_t'($urandom);
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    scan       <= s;
    scan_valid <= 1'b1;
    do @(posedge clk); while (!scan_ready);
    scans_sent++;
  endtask

  // hold a key set for n scans, optionally with contact bounce on one key
  task automatic hold_keys(input logic [15:0] held, input int n, input bit bounce);
    logic [15:0] m;
    repeat (n) begin
      m = held;
      if (bounce && $urandom_range(0, 5) == 0) m ^= 16'h1 << $urandom_range(0, 15);
      push_scan(scan_of(m));
    end
  endtask

  // receiver back-pressure
  initial begin
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (scan_valid && scan_ready) || (result_valid && result_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int  mode;
    int  len;
    bit  paused;
    paused = 1'b0;
    rst        <= 1'b1;
    scan_valid <= 1'b0;
    scan       <= scan_of('0);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle, all keys (early scans then multi-press), single D,
    // two new presses in different columns, full release
    hold_keys(16'h0000, 2, 1'b0);
    hold_keys(16'hFFFF, 5, 1'b0);
    hold_keys(16'h0000, 1, 1'b0);
    hold_keys(16'h8000, 5, 1'b0);
    hold_keys(16'h8140, 5, 1'b0);
    hold_keys(16'h0000, 5, 1'b0);

    while (scans_sent < SCAN_TARGET) begin
      quiet = (scans_sent >= QUIET_FROM);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 50;
        default: gap_pct = 20;
      endcase
      if (!paused && scans_sent >= 600) begin
        // let every outstanding result drain before the next scan
        scan_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        paused = 1'b1;
      end
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 10);
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin
          repeat ($urandom_range(1, 4)) push_scan(ksde_scan_t'($urandom));
        end
        1, 2: begin
          held_now = '0;
          hold_keys(held_now, len, $urandom_range(0, 2) == 0);
        end
        3, 4, 5: begin
          held_now = 16'h1 << $urandom_range(0, 15);
          hold_keys(held_now, len, $urandom_range(0, 2) == 0);
        end
        6, 7: begin
          held_now = 16'($urandom & $urandom & $urandom);
          hold_keys(held_now, len, $urandom_range(0, 2) == 0);
        end
        8: begin
          held_now = 16'($urandom);
          hold_keys(held_now, len, $urandom_range(0, 2) == 0);
        end
        default: begin
          // add or drop one key on top of the current chord
          if ($urandom_range(0, 1) == 0)
            held_now |= 16'h1 << $urandom_range(0, 15);
          else
            held_now &= ~(16'h1 << $urandom_range(0, 15));
          hold_keys(held_now, len, $urandom_range(0, 2) == 0);
        end
      endcase
    end

    scan_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
